[sv/stack_machine_execute_top_assert.svh]
// Assertion macros used by the checker file.
`ifndef STACK_MACHINE_EXECUTE_TOP_ASSERT_SVH
`define STACK_MACHINE_EXECUTE_TOP_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted (active low).
`define SME_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted (active low).
`define SME_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that is also checked through reset.
`define SME_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

[sv/sme_pkg.sv]
package sme_pkg;

  // Opcodes
  localparam logic [3:0] OP_LDI   = 4'd0;
  localparam logic [3:0] OP_LD    = 4'd1;
  localparam logic [3:0] OP_ST    = 4'd2;
  localparam logic [3:0] OP_PUSHI = 4'd3;
  localparam logic [3:0] OP_PUSH  = 4'd4;
  localparam logic [3:0] OP_POP   = 4'd5;
  localparam logic [3:0] OP_ADD   = 4'd6;
  localparam logic [3:0] OP_SUB   = 4'd7;
  localparam logic [3:0] OP_WR    = 4'd8;
  localparam logic [3:0] OP_READ  = 4'd9;

  // Status codes
  localparam logic [2:0] ST_OK      = 3'd0;
  localparam logic [2:0] ST_BADOP   = 3'd1;
  localparam logic [2:0] ST_OVER    = 3'd2;
  localparam logic [2:0] ST_UNDER   = 3'd3;
  localparam logic [2:0] ST_BADADDR = 3'd4;
  localparam logic [2:0] ST_HALTED  = 3'd5;

  // One result transaction
  typedef struct packed {
    logic [2:0]         status;
    logic               read_valid;
    logic signed [31:0] read_value;
    logic [7:0]         stack_count;
  } sme_result_t;

endpackage

[sv/sme_ram.sv]
module sme_ram #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port, old data on a same-address collision
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[sv/sme_ofifo.sv]
module sme_ofifo (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                push,
  input  sme_pkg::sme_result_t push_data,
  input  logic                pop,
  output logic                not_empty,
  output sme_pkg::sme_result_t head,
  output logic [2:0]          level
);

  import sme_pkg::*;

  sme_result_t slot_r [4];
  logic [1:0]  wr_ptr_r;
  logic [1:0]  rd_ptr_r;
  logic [2:0]  count_r;
  logic        do_pop;

  assign do_pop    = pop && (count_r != 3'd0);
  assign not_empty = (count_r != 3'd0);
  assign head      = slot_r[rd_ptr_r];
  assign level     = count_r;

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 2'd0;
      rd_ptr_r <= 2'd0;
      count_r  <= 3'd0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      case ({push, do_pop})
        2'b10:   count_r <= count_r + 3'd1;
        2'b01:   count_r <= count_r - 3'd1;
        default: count_r <= count_r;
      endcase
    end
  end

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

[sv/stack_machine_execute_top.sv]
// Stack machine execute unit: one instruction per input transaction.
//
// Input channel (in_valid/in_ready): in_opcode and in_operand form one
// instruction. Result channel (out_valid/out_ready): one transaction per
// instruction with out_status, out_read_valid, out_read_value and
// out_stack_count, in instruction order.
//
// An accepted instruction is registered into the execute stage, and its result is
// pushed into the output FIFO at the end of the execute cycle, raising out_valid.
// Throughput: one instruction per cycle while in_ready stays high. Memory and stack
// reads are issued at accept, the modify and write back happen in the execute cycle,
// and a write of the previous instruction to the same entry is forwarded.
//
// Reset: data register, stack pointer and halt flag clear at once; then a
// clearing pass zeroes the word memory, one word a cycle, all MEM_WORDS words,
// with in_ready low. Stack contents are not cleared.
//
// Receiver stall: results queue in a four-entry output FIFO; in_ready drops
// when the FIFO plus the instruction in execute would exceed that depth.
module stack_machine_execute_top #(
  parameter int STACK_DEPTH = 128,
  parameter int MEM_WORDS   = 256
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_opcode,
  input  logic signed [31:0] in_operand,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_status,
  output logic               out_read_valid,
  output logic signed [31:0] out_read_value,
  output logic [7:0]         out_stack_count
);

  import sme_pkg::*;

  localparam int AW  = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
  localparam int SW  = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int SPW = $clog2(STACK_DEPTH + 1);

  // Architectural registers
  logic [31:0]    data_r;
  logic [SPW-1:0] sp_r, sp_nxt;
  logic           halted_r, halted_nxt;

  // Clearing pass
  logic           clr_r;
  logic [AW-1:0]  clr_addr_r;

  // Execute stage
  logic           e_v_r;
  logic [3:0]     e_op_r;
  logic           e_ok_r;
  logic [2:0]     e_status_r;
  logic [31:0]    e_operand_r;
  logic [AW-1:0]  e_waddr_r;
  logic [SW-1:0]  e_sidx_r;
  logic [7:0]     e_cnt_r;
  logic           e_wfwd_r, e_sfwd_r;
  logic [31:0]    w_last_r, s_last_r;

  // Accept stage signals
  logic           accept;
  logic           addr_ok;
  logic [2:0]     a_status;
  logic [AW-1:0]  a_waddr;
  logic [SW-1:0]  a_sidx;
  logic [SW-1:0]  a_ridx;

  // Execute stage signals
  logic [31:0]    word_rdata, stk_rdata;
  logic [31:0]    word_q, stk_q;
  logic           word_we, stk_we;
  logic [31:0]    word_wdata, stk_wdata;
  logic [31:0]    data_nxt;
  sme_result_t    e_res;

  // Output FIFO
  sme_result_t    ofifo_head;
  logic [2:0]     ofifo_level;

  // Memory port muxing
  logic           wram_we;
  logic [AW-1:0]  wram_waddr;
  logic [31:0]    wram_wdata;

  assign accept  = in_valid && in_ready;
  assign addr_ok = ({1'b0, in_operand} < 33'(MEM_WORDS));
  assign a_waddr = in_operand[AW-1:0];
  assign a_ridx  = SW'(sp_r - SPW'(1));

  // Decode, check and stack pointer update at accept
  always_comb begin
    a_status   = ST_OK;
    sp_nxt     = sp_r;
    halted_nxt = halted_r;
    a_sidx     = a_ridx;
    if (halted_r) begin
      a_status = ST_HALTED;
    end else if (in_opcode > OP_READ) begin
      a_status   = ST_BADOP;
      halted_nxt = 1'b1;
    end else if ((in_opcode inside {OP_LD, OP_ST, OP_WR, OP_READ}) && !addr_ok) begin
      a_status = ST_BADADDR;
    end else if ((in_opcode inside {OP_PUSHI, OP_PUSH}) && (sp_r >= SPW'(STACK_DEPTH))) begin
      a_status = ST_OVER;
    end else if ((in_opcode inside {[OP_POP:OP_WR]}) && (sp_r == '0)) begin
      a_status = ST_UNDER;
    end else begin
      case (in_opcode)
        OP_PUSHI, OP_PUSH: begin
          a_sidx = sp_r[SW-1:0];
          sp_nxt = sp_r + SPW'(1);
        end
        OP_POP: sp_nxt = sp_r - SPW'(1);
        default: sp_nxt = sp_r;
      endcase
    end
  end

  // Forwarded operands for the instruction in execute
  assign word_q = e_wfwd_r ? w_last_r : word_rdata;
  assign stk_q  = e_sfwd_r ? s_last_r : stk_rdata;

  // Execute: modify and write back
  always_comb begin
    word_we    = 1'b0;
    word_wdata = '0;
    stk_we     = 1'b0;
    stk_wdata  = '0;
    data_nxt   = data_r;
    e_res.status      = e_status_r;
    e_res.read_valid  = 1'b0;
    e_res.read_value  = '0;
    e_res.stack_count = e_cnt_r;
    if (e_v_r && e_ok_r) begin
      case (e_op_r)
        OP_LDI:   data_nxt = e_operand_r;
        OP_LD:    data_nxt = word_q;
        OP_ST: begin
          word_we    = 1'b1;
          word_wdata = data_r;
        end
        OP_PUSHI: begin
          stk_we    = 1'b1;
          stk_wdata = e_operand_r;
        end
        OP_PUSH: begin
          stk_we    = 1'b1;
          stk_wdata = data_r;
        end
        OP_POP:   data_nxt = stk_q;
        OP_ADD: begin
          stk_we    = 1'b1;
          stk_wdata = stk_q + data_r;
        end
        OP_SUB: begin
          stk_we    = 1'b1;
          stk_wdata = stk_q - data_r;
        end
        OP_WR: begin
          word_we    = 1'b1;
          word_wdata = stk_q;
        end
        OP_READ: begin
          e_res.read_valid = 1'b1;
          e_res.read_value = word_q;
          // positive words clear on read-out
          word_we    = (word_q != 32'd0) && !word_q[31];
          word_wdata = '0;
        end
        default: data_nxt = data_r;
      endcase
    end
  end

  // Architectural state and clearing pass
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      data_r     <= '0;
      sp_r       <= '0;
      halted_r   <= 1'b0;
      clr_r      <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      data_r <= data_nxt;
      if (accept) begin
        sp_r     <= sp_nxt;
        halted_r <= halted_nxt;
      end
      if (clr_r) begin
        clr_addr_r <= clr_addr_r + AW'(1);
        if (clr_addr_r == AW'(MEM_WORDS - 1)) begin
          clr_r <= 1'b0;
        end
      end
    end
  end

  // Execute stage valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      e_v_r <= 1'b0;
    end else begin
      e_v_r <= accept;
    end
  end

  // Execute stage payload and forwarding flags
  always_ff @(posedge clk) begin
    w_last_r <= word_wdata;
    s_last_r <= stk_wdata;
    if (accept) begin
      e_op_r      <= in_opcode;
      e_ok_r      <= (a_status == ST_OK);
      e_status_r  <= a_status;
      e_operand_r <= in_operand;
      e_waddr_r   <= a_waddr;
      e_sidx_r    <= a_sidx;
      e_cnt_r     <= 8'(sp_nxt);
      e_wfwd_r    <= word_we && (e_waddr_r == a_waddr);
      e_sfwd_r    <= stk_we && (e_sidx_r == a_ridx);
    end
  end

  // Word memory write port shared with the clearing pass
  assign wram_we    = clr_r || word_we;
  assign wram_waddr = clr_r ? clr_addr_r : e_waddr_r;
  assign wram_wdata = clr_r ? 32'd0 : word_wdata;

  sme_ram #(.DEPTH(MEM_WORDS), .WIDTH(32)) u_word_ram (
    .clk   (clk),
    .we    (wram_we),
    .waddr (wram_waddr),
    .wdata (wram_wdata),
    .re    (accept),
    .raddr (a_waddr),
    .rdata (word_rdata)
  );

  sme_ram #(.DEPTH(STACK_DEPTH), .WIDTH(32)) u_stack_ram (
    .clk   (clk),
    .we    (stk_we),
    .waddr (e_sidx_r),
    .wdata (stk_wdata),
    .re    (accept),
    .raddr (a_ridx),
    .rdata (stk_rdata)
  );

  sme_ofifo u_ofifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (e_v_r),
    .push_data (e_res),
    .pop       (out_ready),
    .not_empty (out_valid),
    .head      (ofifo_head),
    .level     (ofifo_level)
  );

  // Room for one more transaction beyond those queued and in execute
  assign in_ready = !clr_r && ((ofifo_level + {2'b00, e_v_r}) < 3'd4);

  assign out_status      = ofifo_head.status;
  assign out_read_valid  = ofifo_head.read_valid;
  assign out_read_value  = ofifo_head.read_value;
  assign out_stack_count = ofifo_head.stack_count;

endmodule

[sv/sme_checker.sv]
`include "stack_machine_execute_top_assert.svh"

module sme_checker #(
  parameter int STACK_DEPTH = 128
) (
  input logic               clk,
  input logic               rst_n,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic [2:0]         out_status,
  input logic               out_read_valid,
  input logic signed [31:0] out_read_value,
  input logic [7:0]         out_stack_count
);

  import sme_pkg::*;

  // Stalled result holds
  `SME_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_status) && $stable(out_read_valid) && $stable(out_read_value) && $stable(out_stack_count), "stalled result changed")

  // A read-out only comes with ok status
  `SME_ASSERT_SAME(a_read_ok, clk, rst_n, out_valid && out_read_valid, out_status == ST_OK, "read-out with error status")

  // No read-out means a zero read value
  `SME_ASSERT_SAME(a_read_zero, clk, rst_n, out_valid && !out_read_valid, out_read_value == 32'sd0, "read value without read-out")

  // Stack depth never exceeds its size
  `SME_ASSERT_SAME(a_depth, clk, rst_n, out_valid, out_stack_count <= 8'(STACK_DEPTH), "stack depth out of range")

  // Memory clearing keeps the input closed right after reset
  `SME_ASSERT_NEXT_ALWAYS(a_clear_closed, clk, !rst_n, !in_ready, "input open during memory clear")

endmodule

bind stack_machine_execute_top sme_checker #(.STACK_DEPTH(STACK_DEPTH)) u_sme_checker (
  .clk             (clk),
  .rst_n           (rst_n),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .out_status      (out_status),
  .out_read_valid  (out_read_valid),
  .out_read_value  (out_read_value),
  .out_stack_count (out_stack_count)
);

[sim/tb_top.sv]
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import sme_pkg::*;

  localparam int STACK_DEPTH    = 128;
  localparam int MEM_WORDS      = 256;
  // covers the memory clearing pass after reset plus worst-case stalls
  localparam int WATCHDOG_LIMIT = 2000;

  typedef enum {MIX_MODE, FILL_MODE, DRAIN_MODE} traffic_mode_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [3:0]         in_opcode = OP_LDI;
  logic signed [31:0] in_operand = '0;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic               out_read_valid;
  logic signed [31:0] out_read_value;
  logic [7:0]         out_stack_count;

  // machine state mirror
  logic [31:0] data_reg_m;
  logic [31:0] mem_m [MEM_WORDS];
  logic [31:0] stack_m [STACK_DEPTH];
  int          sp_m;
  bit          halted_m;

  sme_result_t machine_results[$];
  int          mismatches = 0;
  int          stuck_cycles = 0;
  bit          idle_on = 1'b1;

  stack_machine_execute_top #(
    .STACK_DEPTH(STACK_DEPTH),
    .MEM_WORDS  (MEM_WORDS)
  ) DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_opcode      (in_opcode),
    .in_operand     (in_operand),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_read_valid (out_read_valid),
    .out_read_value (out_read_value),
    .out_stack_count(out_stack_count)
  );

  always #5 clk = ~clk;

  // Execute one instruction on the mirror, return the result it produces
  function automatic sme_result_t step_machine(logic [3:0] op, logic signed [31:0] arg);
    sme_result_t r;
    bit          addr_op;
    bit          addr_bad;
    int unsigned idx;
    logic [31:0] w;
    r = '0;
    idx = arg;
    addr_op = (op == OP_LD) || (op == OP_ST) || (op == OP_WR) || (op == OP_READ);
    addr_bad = (arg < 0) || (arg >= MEM_WORDS);
    if (halted_m) begin
      r.status = ST_HALTED;
    end else if (op > OP_READ) begin
      r.status = ST_BADOP;
      halted_m = 1'b1;
    end else if (addr_op && addr_bad) begin
      r.status = ST_BADADDR;
    end else if ((op == OP_PUSHI || op == OP_PUSH) && sp_m >= STACK_DEPTH) begin
      r.status = ST_OVER;
    end else if (op >= OP_POP && op <= OP_WR && sp_m == 0) begin
      r.status = ST_UNDER;
    end else begin
      r.status = ST_OK;
      case (op)
        OP_LDI:   data_reg_m = arg;
        OP_LD:    data_reg_m = mem_m[idx];
        OP_ST:    mem_m[idx] = data_reg_m;
        OP_PUSHI: begin
          stack_m[sp_m] = arg;
          sp_m++;
        end
        OP_PUSH:  begin
          stack_m[sp_m] = data_reg_m;
          sp_m++;
        end
        OP_POP:   begin
          sp_m--;
          data_reg_m = stack_m[sp_m];
        end
        OP_ADD:   stack_m[sp_m-1] = stack_m[sp_m-1] + data_reg_m;
        OP_SUB:   stack_m[sp_m-1] = stack_m[sp_m-1] - data_reg_m;
        OP_WR:    mem_m[idx] = stack_m[sp_m-1];
        default: begin
          // read-out clears strictly positive words
          w = mem_m[idx];
          r.read_valid = 1'b1;
          r.read_value = w;
          if (w != 0 && !w[31]) mem_m[idx] = '0;
        end
      endcase
    end
    r.stack_count = sp_m[7:0];
    return r;
  endfunction

  // Drive one instruction and wait for its acceptance
  task automatic issue_instr(input logic [3:0] op, input logic signed [31:0] arg);
    @(negedge clk);
    if (idle_on && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 5)) @(negedge clk);
    end
    in_valid   <= 1'b1;
    in_opcode  <= op;
    in_operand <= arg;
    do @(posedge clk); while (!in_ready);
    machine_results.push_back(step_machine(op, arg));
  endtask

  function automatic logic signed [31:0] pick_addr();
    case ($urandom_range(0, 9))
      0: return $urandom;
      1: return $urandom_range(0, MEM_WORDS - 1);
      default: return $urandom_range(0, 15);
    endcase
  endfunction

  function automatic logic signed [31:0] pick_value();
    case ($urandom_range(0, 7))
      0: return 32'sd0;
      1: return -32'sd1;
      2: return 32'h7fff_ffff;
      3: return 32'h8000_0000;
      4: return $signed($urandom_range(0, 200)) - 100;
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [3:0] pick_opcode(traffic_mode_t mode);
    if (mode == FILL_MODE && $urandom_range(0, 9) < 7)
      return $urandom_range(0, 1) ? OP_PUSHI : OP_PUSH;
    if (mode == DRAIN_MODE && $urandom_range(0, 9) < 7) begin
      case ($urandom_range(0, 3))
        0: return OP_POP;
        1: return OP_ADD;
        2: return OP_SUB;
        default: return OP_WR;
      endcase
    end
    return $urandom_range(OP_LDI, OP_READ);
  endfunction

  // Data register loads and stores, including bad addresses
  task automatic test_data_reg();
    issue_instr(OP_LDI, 32'h7fff_ffff);
    issue_instr(OP_ST, 0);
    issue_instr(OP_LDI, 32'h8000_0000);
    issue_instr(OP_ST, MEM_WORDS - 1);
    issue_instr(OP_LD, 0);
    issue_instr(OP_LD, MEM_WORDS);
    issue_instr(OP_ST, -1);
  endtask

  // Push, pop and arithmetic, underflow on an empty stack
  task automatic test_stack_ops();
    issue_instr(OP_POP, 32'h5a5a_5a5a);
    issue_instr(OP_ADD, 0);
    issue_instr(OP_SUB, -1);
    issue_instr(OP_WR, 300);  // address error wins over underflow
    issue_instr(OP_WR, 3);
    issue_instr(OP_PUSHI, -1);
    issue_instr(OP_PUSH, 0);
    issue_instr(OP_ADD, 0);   // wraps
    issue_instr(OP_SUB, 0);
    issue_instr(OP_WR, 1);
    issue_instr(OP_POP, 0);
  endtask

  // Read-out of positive, zero and negative words
  task automatic test_read_out();
    issue_instr(OP_READ, 0);
    issue_instr(OP_READ, 0);
    issue_instr(OP_READ, MEM_WORDS - 1);
    issue_instr(OP_READ, 1);
    issue_instr(OP_READ, 32'h8000_0000);
  endtask

  // Random programs: mixed, stack filling and stack draining runs
  task automatic test_random_program(input int count);
    traffic_mode_t mode;
    int            run_left;
    logic [3:0]    op;
    logic signed [31:0] arg;
    mode = MIX_MODE;
    run_left = 0;
    for (int i = 0; i < count; i++) begin
      if (run_left == 0) begin
        mode = traffic_mode_t'($urandom_range(0, 2));
        run_left = $urandom_range(20, 150);
        idle_on = ($urandom_range(0, 3) != 0);
      end
      run_left--;
      if (i >= count - 150) idle_on = 1'b0;
      op = pick_opcode(mode);
      case (op)
        OP_LD, OP_ST, OP_WR, OP_READ: arg = pick_addr();
        OP_LDI, OP_PUSHI:             arg = pick_value();
        default:                      arg = $urandom;
      endcase
      issue_instr(op, arg);
    end
  endtask

  // Invalid opcode halts the machine for good
  task automatic test_halt();
    issue_instr(4'd10, 0);
    issue_instr(4'd15, -1);
    issue_instr(OP_LDI, 32'h1234_5678);
    issue_instr(OP_PUSHI, 7);
    issue_instr(OP_READ, 2);
  endtask

  // Receiver stalls
  initial begin
    forever begin
      @(negedge clk);
      if (idle_on && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 4)) @(negedge clk);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  // Compare each result transaction against the oldest prediction
  always @(posedge clk) begin
    sme_result_t exp_r;
    if (rst_n && out_valid && out_ready) begin
      if (machine_results.size() == 0) begin
        $error("unexpected result transaction: status %0d", out_status);
        mismatches++;
      end else begin
        exp_r = machine_results.pop_front();
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, actual %0d", exp_r.status, out_status);
          mismatches++;
        end
        if (out_read_valid !== exp_r.read_valid) begin
          $error("read_valid: expected %0d, actual %0d", exp_r.read_valid, out_read_valid);
          mismatches++;
        end
        if (out_read_value !== exp_r.read_value) begin
          $error("read_value: expected %0d, actual %0d", exp_r.read_value, out_read_value);
          mismatches++;
        end
        if (out_stack_count !== exp_r.stack_count) begin
          $error("stack_count: expected %0d, actual %0d", exp_r.stack_count,
                 out_stack_count);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on cycles without any transaction
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) stuck_cycles <= 0;
    else stuck_cycles <= stuck_cycles + 1;
    if (stuck_cycles >= WATCHDOG_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    data_reg_m = '0;
    sp_m = 0;
    halted_m = 1'b0;
    foreach (mem_m[i]) mem_m[i] = '0;
    foreach (stack_m[i]) stack_m[i] = '0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;

    test_data_reg();
    test_stack_ops();
    test_read_out();
    test_random_program(1000);
    idle_on = 1'b0;
    test_halt();

    @(negedge clk);
    in_valid <= 1'b0;
    wait (machine_results.size() == 0);
    repeat (8) @(posedge clk);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+sv
sv/sme_pkg.sv
sv/sme_ram.sv
sv/sme_ofifo.sv
sv/stack_machine_execute_top.sv
sv/sme_checker.sv
sim/tb_top.sv
